// ----- design/pst_pkg.sv -----
// shared types, constants and helper functions for the pid steering block
`default_nettype none

package pst_pkg;

	// fixed-point layout
	localparam int SAMPLE_WIDTH_DEFAULT = 16;
	localparam int GAIN_WIDTH           = 32;
	localparam int NUM_GAINS            = 3;
	localparam int STEP_WIDTH           = GAIN_WIDTH - 1;
	localparam int IDX_WIDTH            = 2;
	localparam int SQ_WIDTH             = 48;
	localparam int INTEG_WIDTH          = 32;
	localparam int FRAME_WIDTH          = 12;
	localparam int STEER_WIDTH          = 16;
	localparam int ACC_WIDTH            = 64;
	localparam int PROD_CMP_WIDTH       = 66;
	localparam int CFG_IDX_WIDTH        = 3;
	localparam int CFG_DATA_WIDTH       = 32;
	localparam int WARMUP_FRAMES        = 200;

	// reset values of the tuning registers
	localparam logic [STEP_WIDTH-1:0]  STEP_RESET      = STEP_WIDTH'(16777216);
	localparam logic [STEP_WIDTH-1:0]  THRESHOLD_RESET = STEP_WIDTH'(16777);
	localparam logic [FRAME_WIDTH-1:0] EPOCH_RESET     = FRAME_WIDTH'(3200);

	// product saturation bound and output scaling (sum is Q.36)
	localparam logic signed [PROD_CMP_WIDTH-1:0] PROD_POS = 66'sh1000_0000_0000_0000;
	localparam logic signed [PROD_CMP_WIDTH-1:0] PROD_NEG = -PROD_POS;
	localparam logic signed [ACC_WIDTH-1:0]      ONE_Q36  = 64'sh10_0000_0000;
	localparam logic signed [STEER_WIDTH-1:0]    STEER_MAX = 16'sd16384;
	localparam logic signed [STEER_WIDTH-1:0]    STEER_MIN = -16'sd16384;

	// configuration register map
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_KP_INIT        = 3'd0,
		REG_KD_INIT        = 3'd1,
		REG_KI_INIT        = 3'd2,
		REG_KP_STEP_INIT   = 3'd3,
		REG_KD_STEP_INIT   = 3'd4,
		REG_KI_STEP_INIT   = 3'd5,
		REG_STOP_THRESHOLD = 3'd6,
		REG_EPOCH_LENGTH   = 3'd7
	} cfg_reg_t;

	// twiddle trial phase
	typedef enum logic [2:0] {
		PH_BASE  = 3'b001,
		PH_PLUS  = 3'b010,
		PH_MINUS = 3'b100
	} phase_t;

	typedef logic [NUM_GAINS-1:0][GAIN_WIDTH-1:0] gain_vec_t;
	typedef logic [NUM_GAINS-1:0][STEP_WIDTH-1:0] step_vec_t;

	// complete tuner state
	typedef struct packed {
		gain_vec_t             gain;
		step_vec_t             step;
		logic [SQ_WIDTH-1:0]   best;
		logic [IDX_WIDTH-1:0]  idx;
		phase_t                phase;
		logic                  finished;
	} tune_t;

	// side flags that travel with a request down the steering pipeline
	typedef struct packed {
		logic epoch_end;
		logic tuning_done;
	} flags_t;

	// clamp a wide product to plus or minus 2^60
	function automatic logic signed [ACC_WIDTH-1:0] sat_prod(
		input logic signed [PROD_CMP_WIDTH-1:0] p
	);
		logic signed [ACC_WIDTH-1:0] r;
		if (p > PROD_POS)
			r = ACC_WIDTH'(PROD_POS);
		else if (p < PROD_NEG)
			r = ACC_WIDTH'(PROD_NEG);
		else
			r = ACC_WIDTH'(p);
		return r;
	endfunction

	// exact floor(x / 10) for any 32-bit x by reciprocal multiplication
	function automatic logic [31:0] div10(input logic [31:0] x);
		logic [63:0] p;
		p = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
		return 32'(p >> 35);
	endfunction

endpackage

`default_nettype wire

// ----- design/pst_twiddle.sv -----
// one twiddle coordinate-search step applied to the tuner state at epoch end
`default_nettype none

module pst_twiddle (
	input  pst_pkg::tune_t                     tune_cur,
	input  logic [pst_pkg::SQ_WIDTH-1:0]       sq_sum,
	input  logic [pst_pkg::STEP_WIDTH-1:0]     stop_threshold,
	output pst_pkg::tune_t                     tune_nxt
);
	import pst_pkg::*;

	localparam int XW = GAIN_WIDTH + 3;
	localparam int SUM_W = STEP_WIDTH + 2;

	// saturate a widened gain back to GAIN_WIDTH
	function automatic logic [GAIN_WIDTH-1:0] sat_gain(input logic signed [XW-1:0] v);
		logic [GAIN_WIDTH-1:0] r;
		if (&v[XW-1:GAIN_WIDTH-1] || ~|v[XW-1:GAIN_WIDTH-1])
			r = v[GAIN_WIDTH-1:0];
		else if (v[XW-1])
			r = {1'b1, {(GAIN_WIDTH-1){1'b0}}};
		else
			r = {1'b0, {(GAIN_WIDTH-1){1'b1}}};
		return r;
	endfunction

	// sum of the three steps
	function automatic logic [SUM_W-1:0] step_total(input step_vec_t s);
		logic [SUM_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < NUM_GAINS; i++)
			acc = acc + SUM_W'(s[i]);
		return acc;
	endfunction

	logic [IDX_WIDTH-1:0]  n;
	logic [IDX_WIDTH-1:0]  m;
	logic [IDX_WIDTH-1:0]  p;
	logic [SQ_WIDTH-1:0]   best_eff;
	logic                  better;
	logic                  stop_first;
	logic                  stop_second;
	logic                  do_plus;
	logic [STEP_WIDTH-1:0] s_n;
	logic signed [XW-1:0]  g_n;
	logic [31:0]           grow_w;
	logic [STEP_WIDTH-1:0] s_grow;
	logic [STEP_WIDTH-1:0] s_shrink;
	logic signed [XW-1:0]  s_n_x;
	tune_t                 t;

	// working index, next index and the current step
	assign n = (tune_cur.idx < IDX_WIDTH'(NUM_GAINS)) ? tune_cur.idx : '0;
	assign m = (n == IDX_WIDTH'(NUM_GAINS - 1)) ? '0 : n + IDX_WIDTH'(1);
	assign s_n = tune_cur.step[n];
	assign g_n = XW'($signed(tune_cur.gain[n]));
	assign s_n_x = XW'($signed({1'b0, s_n}));

	// step grows by 1.1 and shrinks by 0.9, both rounded to nearest
	assign grow_w   = 32'(s_n) + div10(32'(s_n) + 32'd5);
	assign s_grow   = grow_w[31] ? {STEP_WIDTH{1'b1}} : grow_w[STEP_WIDTH-1:0];
	assign s_shrink = s_n - STEP_WIDTH'(div10(32'(s_n) + 32'd4));

	// a best error of zero means unset and takes the current sum
	assign best_eff   = (tune_cur.best == '0) ? sq_sum : tune_cur.best;
	assign better     = sq_sum < best_eff;
	assign stop_first = tune_cur.finished ||
		(step_total(tune_cur.step) < SUM_W'(stop_threshold));

	// trial sequencing
	always_comb begin
		t = tune_cur;
		t.best = best_eff;
		do_plus = 1'b0;
		p = n;
		stop_second = 1'b0;
		if (stop_first) begin
			t.finished = 1'b1;
		end else begin
			unique case (tune_cur.phase)
				PH_PLUS: begin
					if (better) begin
						t.step[n] = s_grow;
						t.best = sq_sum;
						do_plus = 1'b1;
						p = m;
					end else begin
						t.gain[n] = sat_gain(g_n - (s_n_x <<< 1));
						t.phase = PH_MINUS;
					end
				end
				PH_MINUS: begin
					if (better) begin
						t.step[n] = s_grow;
						t.best = sq_sum;
					end else begin
						t.gain[n] = sat_gain(g_n + s_n_x);
						t.step[n] = s_shrink;
					end
					do_plus = 1'b1;
					p = m;
				end
				default: begin
					do_plus = 1'b1;
					p = n;
				end
			endcase
			// next trial: raise the chosen gain unless the steps have run out
			if (do_plus) begin
				stop_second = step_total(t.step) < SUM_W'(stop_threshold);
				t.idx = p;
				if (stop_second) begin
					t.finished = 1'b1;
					t.phase = PH_BASE;
				end else begin
					t.gain[p] = sat_gain(XW'($signed(t.gain[p])) +
						XW'($signed({1'b0, t.step[p]})));
					t.phase = PH_PLUS;
				end
			end
		end
	end

	assign tune_nxt = t;

endmodule

`default_nettype wire

// ----- design/pst_steer.sv -----
// steering output pipeline: gain products, then sum, rounding and clamp
`default_nettype none

module pst_steer #(
	parameter int SAMPLE_WIDTH = pst_pkg::SAMPLE_WIDTH_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   op_valid,
	output logic                                   op_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]         cte,
	input  logic signed [SAMPLE_WIDTH:0]           diff,
	input  logic signed [pst_pkg::INTEG_WIDTH-1:0] integ,
	input  pst_pkg::gain_vec_t                     gain,
	input  pst_pkg::flags_t                        flags,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output logic signed [pst_pkg::STEER_WIDTH-1:0] steer,
	output pst_pkg::flags_t                        res_flags
);
	import pst_pkg::*;

	logic signed [GAIN_WIDTH+SAMPLE_WIDTH-1:0]  prod_p;
	logic signed [GAIN_WIDTH+SAMPLE_WIDTH:0]    prod_d;
	logic signed [GAIN_WIDTH+INTEG_WIDTH-1:0]   prod_i;
	logic signed [ACC_WIDTH-1:0]                prod_p_s3;
	logic signed [ACC_WIDTH-1:0]                prod_d_s3;
	logic signed [ACC_WIDTH-1:0]                prod_i_s3;
	flags_t                                     flags_s3;
	logic                                       valid_s3;
	logic                                       res_free;
	logic                                       ready_s3;
	logic signed [ACC_WIDTH-1:0]                acc;
	logic signed [ACC_WIDTH-1:0]                neg;
	logic [ACC_WIDTH-1:0]                       biased;
	logic [37:0]                                rounded;
	logic signed [STEER_WIDTH-1:0]              steer_nxt;
	logic signed [STEER_WIDTH-1:0]              steer_q;
	flags_t                                     flags_q;
	logic                                       valid_q;

	// stall chain from the result register backwards
	assign res_free = !valid_q || res_ready;
	assign ready_s3 = !valid_s3 || res_free;
	assign op_ready = ready_s3;

	// the three gain products
	assign prod_p = $signed(gain[0]) * cte;
	assign prod_d = $signed(gain[1]) * diff;
	assign prod_i = $signed(gain[2]) * integ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && op_valid) begin
			prod_p_s3 <= sat_prod(PROD_CMP_WIDTH'(prod_p));
			prod_d_s3 <= sat_prod(PROD_CMP_WIDTH'(prod_d));
			prod_i_s3 <= sat_prod(PROD_CMP_WIDTH'(prod_i));
			flags_s3  <= flags;
		end
	end

	// negate, round half up to Q1.14 and clamp to plus or minus one
	assign acc     = prod_p_s3 + prod_d_s3 + prod_i_s3;
	assign neg     = -acc;
	assign biased  = $unsigned(neg + ONE_Q36);
	assign rounded = biased[37:0] + 38'(1 << 21);

	always_comb begin
		if (neg >= ONE_Q36)
			steer_nxt = STEER_MAX;
		else if (neg <= -ONE_Q36)
			steer_nxt = STEER_MIN;
		else
			steer_nxt = $signed(STEER_WIDTH'(rounded >> 22) - STEER_WIDTH'(16384));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_free) begin
			valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && valid_s3) begin
			steer_q <= steer_nxt;
			flags_q <= flags_s3;
		end
	end

	assign res_valid = valid_q;
	assign steer     = steer_q;
	assign res_flags = flags_q;

endmodule

`default_nettype wire

// ----- design/pid_steer_with_twiddle_tuning.sv -----
// top level: pid steering controller with twiddle gain tuning
//
// One cross-track error request (Q4.12) enters on in_valid/in_ready and
// yields one result (steer Q1.14, epoch_end, tuning_done) on
// out_valid/out_ready. Requests are taken back to back, one per cycle
// unless stalled, and pass the operand (state update), product (gain
// products) and result (sum and rounding) registers. The running sums,
// frame count and, at an epoch end, one full twiddle step are updated
// in the single cycle a request leaves the input register, so the state
// recurrence sets the one-cycle rate. A stalled receiver holds the result
// register; the stall then travels back stage by stage and in_ready falls
// only once every stage is full. Reset clears the pipeline and the tuner
// state and loads the gains, steps, stop threshold and epoch length from
// their reset values. The configuration port writes one register per
// cycle with no handshake; a gain or step write also loads the working
// value. Writes are expected only while the block is idle.
`default_nettype none

module pid_steer_with_twiddle_tuning #(
	parameter int SAMPLE_WIDTH = pst_pkg::SAMPLE_WIDTH_DEFAULT
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]            cross_track_error,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [pst_pkg::STEER_WIDTH-1:0]    steer,
	output logic                                      epoch_end,
	output logic                                      tuning_done,
	input  logic                                      cfg_we,
	input  logic [pst_pkg::CFG_IDX_WIDTH-1:0]         cfg_index,
	input  logic [pst_pkg::CFG_DATA_WIDTH-1:0]        cfg_wdata
);
	import pst_pkg::*;

	localparam int SQ_ADD_W = ((2 * SAMPLE_WIDTH > SQ_WIDTH) ? 2 * SAMPLE_WIDTH : SQ_WIDTH) + 1;

	// pipeline registers
	logic                            valid_s1;
	logic signed [SAMPLE_WIDTH-1:0]  cte_s1;
	logic                            valid_s2;
	logic signed [SAMPLE_WIDTH-1:0]  cte_s2;
	logic signed [SAMPLE_WIDTH:0]    diff_s2;
	logic signed [INTEG_WIDTH-1:0]   integ_s2;
	gain_vec_t                       gain_s2;
	flags_t                          flags_s2;
	logic                            ready_s2;
	logic                            steer_ready;
	logic                            advance;

	// controller state
	tune_t                           tune_q;
	tune_t                           tune_nxt;
	logic [STEP_WIDTH-1:0]           threshold_q;
	logic [FRAME_WIDTH-1:0]          epoch_len_q;
	logic [SQ_WIDTH-1:0]             sq_sum_q;
	logic signed [INTEG_WIDTH-1:0]   integ_q;
	logic signed [SAMPLE_WIDTH-1:0]  last_q;
	logic                            have_last_q;
	logic [FRAME_WIDTH-1:0]          frame_q;

	// per-request next values
	logic signed [2*SAMPLE_WIDTH-1:0] sq_prod;
	logic [SQ_ADD_W-1:0]              sq_add;
	logic [SQ_WIDTH-1:0]              sq_new;
	logic [FRAME_WIDTH:0]             frame_inc;
	logic [FRAME_WIDTH-1:0]           frame_nxt;
	logic                             ended;
	logic signed [INTEG_WIDTH:0]      integ_add;
	logic signed [INTEG_WIDTH-1:0]    integ_sat;
	logic signed [INTEG_WIDTH-1:0]    integ_new;
	logic signed [SAMPLE_WIDTH:0]     diff;
	flags_t                           res_flags;

	// stall chain
	assign ready_s2 = !valid_s2 || steer_ready;
	assign in_ready = !valid_s1 || ready_s2;
	assign advance  = valid_s1 && ready_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cte_s1 <= cross_track_error;
		end
	end

	// squared error sum, saturating at 48 bits
	assign sq_prod = cte_s1 * cte_s1;
	assign sq_add  = SQ_ADD_W'($unsigned(sq_prod)) + SQ_ADD_W'(sq_sum_q);
	assign sq_new  = (sq_add > SQ_ADD_W'({SQ_WIDTH{1'b1}})) ?
		{SQ_WIDTH{1'b1}} : sq_add[SQ_WIDTH-1:0];

	// frame counter wraps at the epoch length
	assign frame_inc = (FRAME_WIDTH + 1)'(frame_q) + (FRAME_WIDTH + 1)'(1);
	assign frame_nxt = (frame_inc >= (FRAME_WIDTH + 1)'(epoch_len_q)) ?
		'0 : frame_inc[FRAME_WIDTH-1:0];
	assign ended = (frame_nxt == '0);

	// integral accumulates after the warm-up frames, saturating at 32 bits
	assign integ_add = (INTEG_WIDTH + 1)'(integ_q) + (INTEG_WIDTH + 1)'(cte_s1);
	assign integ_sat = (integ_add[INTEG_WIDTH] != integ_add[INTEG_WIDTH-1]) ?
		(integ_add[INTEG_WIDTH] ? {1'b1, {(INTEG_WIDTH-1){1'b0}}}
			: {1'b0, {(INTEG_WIDTH-1){1'b1}}})
		: integ_add[INTEG_WIDTH-1:0];
	assign integ_new = (frame_nxt > FRAME_WIDTH'(WARMUP_FRAMES)) ? integ_sat : integ_q;

	// difference to the previous sample of the epoch
	assign diff = have_last_q ?
		((SAMPLE_WIDTH + 1)'(cte_s1) - (SAMPLE_WIDTH + 1)'(last_q)) : '0;

	pst_twiddle u_twiddle (
		.tune_cur       (tune_q),
		.sq_sum         (sq_new),
		.stop_threshold (threshold_q),
		.tune_nxt       (tune_nxt)
	);

	// running sums and frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_sum_q    <= '0;
			integ_q     <= '0;
			last_q      <= '0;
			have_last_q <= 1'b0;
			frame_q     <= '0;
		end else if (advance) begin
			sq_sum_q    <= ended ? '0 : sq_new;
			integ_q     <= ended ? '0 : integ_new;
			last_q      <= cte_s1;
			have_last_q <= !ended;
			frame_q     <= frame_nxt;
		end
	end

	// tuner state: configuration writes load it, epoch ends step it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_q.gain     <= '0;
			tune_q.step     <= {NUM_GAINS{STEP_RESET}};
			tune_q.best     <= '0;
			tune_q.idx      <= '0;
			tune_q.phase    <= PH_BASE;
			tune_q.finished <= 1'b0;
			threshold_q     <= THRESHOLD_RESET;
			epoch_len_q     <= EPOCH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KP_INIT:        tune_q.gain[0] <= cfg_wdata[GAIN_WIDTH-1:0];
				REG_KD_INIT:        tune_q.gain[1] <= cfg_wdata[GAIN_WIDTH-1:0];
				REG_KI_INIT:        tune_q.gain[2] <= cfg_wdata[GAIN_WIDTH-1:0];
				REG_KP_STEP_INIT:   tune_q.step[0] <= cfg_wdata[STEP_WIDTH-1:0];
				REG_KD_STEP_INIT:   tune_q.step[1] <= cfg_wdata[STEP_WIDTH-1:0];
				REG_KI_STEP_INIT:   tune_q.step[2] <= cfg_wdata[STEP_WIDTH-1:0];
				REG_STOP_THRESHOLD: threshold_q    <= cfg_wdata[STEP_WIDTH-1:0];
				REG_EPOCH_LENGTH:   epoch_len_q    <= cfg_wdata[FRAME_WIDTH-1:0];
				default: ;
			endcase
		end else if (advance && ended) begin
			tune_q <= tune_nxt;
		end
	end

	// operand register: steer uses the gains held before this request's twiddle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cte_s2               <= cte_s1;
			diff_s2              <= diff;
			integ_s2             <= integ_new;
			gain_s2              <= tune_q.gain;
			flags_s2.epoch_end   <= ended;
			flags_s2.tuning_done <= ended ? tune_nxt.finished : tune_q.finished;
		end
	end

	pst_steer #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_steer (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (valid_s2),
		.op_ready  (steer_ready),
		.cte       (cte_s2),
		.diff      (diff_s2),
		.integ     (integ_s2),
		.gain      (gain_s2),
		.flags     (flags_s2),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.steer     (steer),
		.res_flags (res_flags)
	);

	assign epoch_end   = res_flags.epoch_end;
	assign tuning_done = res_flags.tuning_done;

endmodule

`default_nettype wire
